[rtl/idoi_pkg.sv]
// Shared types, constants and the side score function of the depth-order insert unit.
package idoi_pkg;

    localparam int CAPACITY  = 32;
    localparam int OUT_LIMIT = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 16;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_EMPTY     = 2'd3;

    typedef struct packed {
        logic [14:0]        height;
        logic [14:0]        width;
        logic signed [15:0] top;
        logic signed [15:0] left;
        logic [7:0]         id;
    } entry_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_READ_LAST,
        CMD_APPEND,
        CMD_SCAN_LOW,
        CMD_PUT_NEW,
        CMD_SCAN_HIGH,
        CMD_INS_DONE,
        CMD_SCAN_RM,
        CMD_RM_DONE,
        CMD_RESP_FULL,
        CMD_RESP_EMPTY,
        CMD_OUT_READ,
        CMD_OUT_LOAD,
        CMD_OUT_NEXT
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RL_ISSUE,
        ST_RL_EVAL,
        ST_APPEND,
        ST_SCAN_LOW,
        ST_PUT_NEW,
        ST_SCAN_HIGH,
        ST_INS_DONE,
        ST_SCAN_RM,
        ST_RM_DONE,
        ST_OUT_READ,
        ST_OUT_LOAD,
        ST_OUT_SEND,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       count_zero;
        logic       count_full;
        logic       side_neg;
        logic       scan_done;
        logic       out_last;
    } dp_status_t;

    function automatic logic signed [1:0] axis_score(
        input logic signed [15:0] snear,
        input logic [14:0]        ssize,
        input logic signed [15:0] nnear,
        input logic [14:0]        nsize
    );
        logic signed [16:0] sfar;
        logic signed [16:0] nfar;
        logic signed [1:0]  score;
        sfar = 17'(snear) + $signed({2'b00, ssize});
        nfar = 17'(nnear) + $signed({2'b00, nsize});
        if (17'(nnear) >= sfar) begin
            score = 2'sd1;
        end else if (nfar <= 17'(snear)) begin
            score = -2'sd1;
        end else begin
            score = 2'sd0;
        end
        return score;
    endfunction

    function automatic logic signed [2:0] side_of(input entry_t stored, input entry_t fresh);
        logic signed [2:0] hs;
        logic signed [2:0] vs;
        hs = 3'(axis_score(stored.left, stored.width, fresh.left, fresh.width));
        vs = 3'(axis_score(stored.top, stored.height, fresh.top, fresh.height));
        return hs + vs;
    endfunction

endpackage

[rtl/idoi_datapath.sv]
// Datapath: double-banked entry memory, scan counters, partition flags and result register.
module idoi_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  idoi_pkg::cmd_t                cmd,
    input  logic [idoi_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [1:0]                    s_tuser,
    output idoi_pkg::dp_status_t          status,
    output logic [idoi_pkg::M_DATA_W-1:0] m_tdata,
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);
    import idoi_pkg::*;

    entry_t mem [2*CAPACITY];
    entry_t rdata_reg;

    entry_t              item_reg, item_next;
    logic [1:0]          mode_reg, mode_next;
    logic                bank_reg, bank_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [CAPACITY-1:0] after_reg, after_next;
    logic                max_seen_reg, max_seen_next;
    logic                found_reg, found_next;
    logic [7:0]          out_id_reg, out_id_next;
    logic [5:0]          out_pos_reg, out_pos_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic                we, re;
    logic [ADDR_W-1:0]   waddr, raddr;
    entry_t              wdata;
    logic signed [2:0]   side;
    logic [CNT_W-1:0]    cnt_m1;
    logic [CNT_W-1:0]    lim;
    logic [CNT_W:0]      rd_idx_p1;
    logic                sel_after;

    assign side      = side_of(rdata_reg, item_reg);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign lim       = (int'(count_reg) > OUT_LIMIT) ? CNT_W'(OUT_LIMIT) : count_reg;
    assign rd_idx_p1 = {1'b0, rd_idx_reg} + (CNT_W+1)'(1);

    always_comb begin
        item_next       = item_reg;
        mode_next       = mode_reg;
        bank_next       = bank_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        k_next          = k_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        after_next      = after_reg;
        max_seen_next   = max_seen_reg;
        found_next      = found_reg;
        out_id_next     = out_id_reg;
        out_pos_next    = out_pos_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        we              = 1'b0;
        re              = 1'b0;
        waddr           = '0;
        raddr           = '0;
        wdata           = item_reg;
        sel_after       = 1'b0;
        case (cmd)
            CMD_LOAD: begin
                item_next     = entry_t'(s_tdata[69:0]);
                mode_next     = s_tuser;
                rd_idx_next   = '0;
                k_next        = '0;
                max_seen_next = 1'b0;
                found_next    = 1'b0;
            end
            CMD_READ_LAST: begin
                re    = 1'b1;
                raddr = {bank_reg, cnt_m1[IDX_W-1:0]};
            end
            CMD_APPEND: begin
                we              = 1'b1;
                waddr           = {bank_reg, count_reg[IDX_W-1:0]};
                count_next      = count_reg + CNT_W'(1);
                out_id_next     = item_reg.id;
                out_pos_next    = '0;
                out_status_next = STATUS_OK;
                out_last_next   = 1'b1;
            end
            CMD_SCAN_LOW, CMD_SCAN_HIGH, CMD_SCAN_RM: begin
                if (rd_idx_reg < count_reg) begin
                    re            = 1'b1;
                    raddr         = {bank_reg, rd_idx_reg[IDX_W-1:0]};
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[IDX_W-1:0];
                end
                if (pend_reg) begin
                    wdata = rdata_reg;
                    waddr = {~bank_reg, k_reg[IDX_W-1:0]};
                    case (cmd)
                        CMD_SCAN_LOW: begin
                            sel_after = (side > 3'sd0) || ((side == 3'sd0) && max_seen_reg);
                            after_next[pend_idx_reg] = sel_after;
                            if (side > 3'sd0) begin
                                max_seen_next = 1'b1;
                            end
                            we = !sel_after;
                        end
                        CMD_SCAN_HIGH: begin
                            we = after_reg[pend_idx_reg];
                        end
                        default: begin
                            if (!found_reg && (rdata_reg.id == item_reg.id)) begin
                                found_next = 1'b1;
                            end else begin
                                we = 1'b1;
                            end
                        end
                    endcase
                    if (we) begin
                        k_next = k_reg + CNT_W'(1);
                    end
                end
            end
            CMD_PUT_NEW: begin
                we          = 1'b1;
                waddr       = {~bank_reg, k_reg[IDX_W-1:0]};
                k_next      = k_reg + CNT_W'(1);
                rd_idx_next = '0;
            end
            CMD_INS_DONE: begin
                bank_next       = ~bank_reg;
                count_next      = count_reg + CNT_W'(1);
                out_id_next     = item_reg.id;
                out_pos_next    = '0;
                out_status_next = STATUS_OK;
                out_last_next   = 1'b1;
            end
            CMD_RM_DONE: begin
                out_id_next   = item_reg.id;
                out_pos_next  = '0;
                out_last_next = 1'b1;
                if (found_reg) begin
                    bank_next       = ~bank_reg;
                    count_next      = cnt_m1;
                    out_status_next = STATUS_OK;
                end else begin
                    out_status_next = STATUS_NOT_FOUND;
                end
            end
            CMD_RESP_FULL: begin
                out_id_next     = item_reg.id;
                out_pos_next    = '0;
                out_status_next = STATUS_FULL;
                out_last_next   = 1'b1;
            end
            CMD_RESP_EMPTY: begin
                out_id_next     = '0;
                out_pos_next    = '0;
                out_status_next = STATUS_EMPTY;
                out_last_next   = 1'b1;
            end
            CMD_OUT_READ: begin
                re    = 1'b1;
                raddr = {bank_reg, rd_idx_reg[IDX_W-1:0]};
            end
            CMD_OUT_LOAD: begin
                out_id_next     = rdata_reg.id;
                out_pos_next    = rd_idx_p1[5:0];
                out_status_next = STATUS_OK;
                out_last_next   = (rd_idx_p1 == {1'b0, lim});
            end
            CMD_OUT_NEXT: begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg  <= 1'b0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            bank_reg  <= bank_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        item_reg       <= item_next;
        mode_reg       <= mode_next;
        rd_idx_reg     <= rd_idx_next;
        k_reg          <= k_next;
        pend_idx_reg   <= pend_idx_next;
        after_reg      <= after_next;
        max_seen_reg   <= max_seen_next;
        found_reg      <= found_next;
        out_id_reg     <= out_id_next;
        out_pos_reg    <= out_pos_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign status.mode       = mode_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.count_full = (int'(count_reg) >= CAPACITY);
    assign status.side_neg   = (side < 3'sd0);
    assign status.scan_done  = (rd_idx_reg >= count_reg) && !pend_reg;
    assign status.out_last   = out_last_reg;

    assign m_tdata = {2'b00, out_pos_reg, out_id_reg};
    assign m_tuser = out_status_reg;
    assign m_tlast = out_last_reg;

endmodule

[rtl/idoi_controller.sv]
// Controller: sequences insert, remove and read-out over the datapath.
module idoi_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  idoi_pkg::dp_status_t status,
    output idoi_pkg::cmd_t       cmd
);
    import idoi_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (status.mode)
                    MODE_INSERT: begin
                        if (status.count_full) begin
                            state_next = ST_RESP;
                        end else if (status.count_zero) begin
                            state_next = ST_APPEND;
                        end else begin
                            state_next = ST_RL_ISSUE;
                        end
                    end
                    MODE_REMOVE: state_next = ST_SCAN_RM;
                    MODE_READ: begin
                        if (status.count_zero) begin
                            state_next = ST_RESP;
                        end else begin
                            state_next = ST_OUT_READ;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_RL_ISSUE: state_next = ST_RL_EVAL;
            ST_RL_EVAL: state_next = status.side_neg ? ST_APPEND : ST_SCAN_LOW;
            ST_APPEND: state_next = ST_RESP;
            ST_SCAN_LOW: begin
                if (status.scan_done) begin
                    state_next = ST_PUT_NEW;
                end
            end
            ST_PUT_NEW: state_next = ST_SCAN_HIGH;
            ST_SCAN_HIGH: begin
                if (status.scan_done) begin
                    state_next = ST_INS_DONE;
                end
            end
            ST_INS_DONE: state_next = ST_RESP;
            ST_SCAN_RM: begin
                if (status.scan_done) begin
                    state_next = ST_RM_DONE;
                end
            end
            ST_RM_DONE: state_next = ST_RESP;
            ST_OUT_READ: state_next = ST_OUT_LOAD;
            ST_OUT_LOAD: state_next = ST_OUT_SEND;
            ST_OUT_SEND: begin
                if (m_tready) begin
                    state_next = status.out_last ? ST_IDLE : ST_OUT_READ;
                end
            end
            ST_RESP: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = CMD_NONE;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd = CMD_LOAD;
                end
            end
            ST_DISPATCH: begin
                if (status.mode == MODE_INSERT && status.count_full) begin
                    cmd = CMD_RESP_FULL;
                end else if (status.mode == MODE_READ && status.count_zero) begin
                    cmd = CMD_RESP_EMPTY;
                end
            end
            ST_RL_ISSUE:  cmd = CMD_READ_LAST;
            ST_APPEND:    cmd = CMD_APPEND;
            ST_SCAN_LOW:  cmd = CMD_SCAN_LOW;
            ST_PUT_NEW:   cmd = CMD_PUT_NEW;
            ST_SCAN_HIGH: cmd = CMD_SCAN_HIGH;
            ST_INS_DONE:  cmd = CMD_INS_DONE;
            ST_SCAN_RM:   cmd = CMD_SCAN_RM;
            ST_RM_DONE:   cmd = CMD_RM_DONE;
            ST_OUT_READ:  cmd = CMD_OUT_READ;
            ST_OUT_LOAD:  cmd = CMD_OUT_LOAD;
            ST_OUT_SEND: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd = CMD_OUT_NEXT;
                end
            end
            ST_RESP: m_tvalid = 1'b1;
            default: cmd = CMD_NONE;
        endcase
    end

endmodule

[rtl/isometric_depth_order_insert_unit.sv]
// Top level of the isometric depth-order insert unit.
// Keeps a draw-order list of up to 32 tagged rectangles in a two-bank entry memory.
// Input channel s_*: one item per command; s_tuser carries the mode (insert, remove,
// read out), s_tdata the id and the rectangle. The unit takes one item at a time:
// s_tready is high only while no earlier item is still at work or waiting to be taken.
// Result channel m_*: m_tdata carries id and 1-based position, m_tuser the status,
// m_tlast marks the final result of an item.
// Insert among n stored entries: each entry is read once per pass through the single
// memory read port, one pass for the part before the new entry and one for the part
// after it, writing the other bank. An insert behind the last entry, or into an empty
// list, appends without a pass. Remove makes one copy pass. Read out sends one result
// per stored entry, each read from memory before it is sent. A full-list insert and
// an empty-list read out answer without a pass. The next item can be taken in the
// cycle after the last result of an item leaves.
// Reset empties the list at once; no clearing pass is needed.
// While the receiver holds m_tready low the result stays on m_* unchanged and the
// unit takes no new item.
module isometric_depth_order_insert_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // item_id[7:0], rect_left[23:8], rect_top[39:24], rect_width[54:40],
    // rect_height[69:55], zero[71:70]
    input  logic [71:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_id[7:0], out_position[13:8], zero[15:14]
    output logic [15:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import idoi_pkg::*;

    cmd_t       cmd;
    dp_status_t status;

    idoi_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    idoi_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

[verif/tb.sv]
// Self-checking testbench for the isometric depth-order insert unit.
`timescale 1ns / 1ps

module tb;
    import idoi_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    typedef struct {
        logic [7:0] id;
        logic [5:0] pos;
        logic [1:0] st;
        logic       last;
    } order_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    entry_t        list_q[$];
    order_result_t pending_q[$];
    int            err_count = 0;
    int            cycle_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    isometric_depth_order_insert_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int axis_side(logic signed [15:0] sn, logic [14:0] ss,
                                     logic signed [15:0] nn, logic [14:0] ns);
        int sfar;
        int nfar;
        sfar = int'(sn) + int'(ss);
        nfar = int'(nn) + int'(ns);
        if (int'(nn) >= sfar) return 1;
        if (nfar <= int'(sn)) return -1;
        return 0;
    endfunction

    function automatic int rect_side(entry_t a, entry_t b);
        return axis_side(a.left, a.width, b.left, b.width) +
               axis_side(a.top, a.height, b.top, b.height);
    endfunction

    function automatic order_result_t mk(int id, int pos, int st, int last);
        order_result_t r;
        r.id = 8'(id); r.pos = 6'(pos); r.st = 2'(st); r.last = 1'(last);
        return r;
    endfunction

    task automatic predict_order(logic [1:0] mode, entry_t e);
        entry_t low_q[$];
        entry_t high_q[$];
        bit     seen_pos;
        int     s;
        int     n;
        int     hit;
        n = list_q.size();
        seen_pos = 0;
        hit = -1;
        if (mode == MODE_INSERT) begin
            if (n >= CAPACITY) begin
                pending_q.push_back(mk(int'(e.id), 0, int'(STATUS_FULL), 1));
            end else begin
                if (n == 0 || rect_side(list_q[n-1], e) < 0) begin
                    list_q.push_back(e);
                end else begin
                    foreach (list_q[i]) begin
                        s = rect_side(list_q[i], e);
                        if (s > 0) seen_pos = 1;
                        if (s > 0 || (s == 0 && seen_pos)) high_q.push_back(list_q[i]);
                        else low_q.push_back(list_q[i]);
                    end
                    list_q = {low_q, e, high_q};
                end
                pending_q.push_back(mk(int'(e.id), 0, int'(STATUS_OK), 1));
            end
        end else if (mode == MODE_REMOVE) begin
            foreach (list_q[i]) if (hit < 0 && list_q[i].id == e.id) hit = i;
            if (hit < 0) begin
                pending_q.push_back(mk(int'(e.id), 0, int'(STATUS_NOT_FOUND), 1));
            end else begin
                list_q.delete(hit);
                pending_q.push_back(mk(int'(e.id), 0, int'(STATUS_OK), 1));
            end
        end else if (mode == MODE_READ) begin
            if (n == 0) pending_q.push_back(mk(0, 0, int'(STATUS_EMPTY), 1));
            if (n > OUT_LIMIT) n = OUT_LIMIT;
            for (int i = 0; i < n; i++)
                pending_q.push_back(mk(int'(list_q[i].id), i + 1, int'(STATUS_OK),
                                       int'(i == n - 1)));
        end
    endtask

    task automatic send_item(logic [1:0] mode, entry_t e);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        predict_order(mode, e);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, e};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    always @(posedge aclk) begin
        order_result_t w;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_q.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    w = pending_q.pop_front();
                    if (m_tdata[7:0] !== w.id)
                        report_mismatch("out_id", int'(m_tdata[7:0]), int'(w.id));
                    if (m_tdata[13:8] !== w.pos)
                        report_mismatch("out_position", int'(m_tdata[13:8]), int'(w.pos));
                    if (m_tdata[15:14] !== 2'b00)
                        report_mismatch("pad", int'(m_tdata[15:14]), 0);
                    if (m_tuser !== w.st) report_mismatch("status", int'(m_tuser), int'(w.st));
                    if (m_tlast !== w.last)
                        report_mismatch("last", int'(m_tlast), int'(w.last));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic entry_t rand_rect(int id);
        entry_t e;
        e.id = 8'(id);
        if ($urandom_range(3) == 0) begin
            e.left = 16'($urandom); e.top = 16'($urandom);
            e.width = 15'($urandom); e.height = 15'($urandom);
        end else begin
            e.left = 16'($signed($urandom_range(200)) - 100);
            e.top = 16'($signed($urandom_range(200)) - 100);
            e.width = 15'($urandom_range(40)); e.height = 15'($urandom_range(40));
        end
        return e;
    endfunction

    function automatic entry_t rect(int id, int l, int t, int w, int h);
        entry_t e;
        e.id = 8'(id); e.left = 16'(l); e.top = 16'(t); e.width = 15'(w); e.height = 15'(h);
        return e;
    endfunction

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_item(MODE_READ, rect(0, 0, 0, 0, 0));
        send_item(MODE_REMOVE, rect(255, 0, 0, 0, 0));
        send_item(MODE_INSERT, rect(1, 0, 0, 10, 10));
        send_item(MODE_INSERT, rect(2, 10, 10, 10, 10));
        send_item(MODE_INSERT, rect(3, -20, -20, 5, 5));
        send_item(MODE_INSERT, rect(4, 5, 5, 10, 10));
        send_item(MODE_INSERT, rect(4, -32768, 32767, 32767, 0));
        send_item(MODE_INSERT, rect(255, 32767, -32768, 0, 32767));
        send_item(MODE_INSERT, rect(0, 0, 0, 0, 0));
        send_item(MODE_IGNORED, rect(9, 1, 1, 1, 1));
        send_item(MODE_READ, rect(0, 0, 0, 0, 0));
        send_item(MODE_REMOVE, rect(4, 0, 0, 0, 0));
        send_item(MODE_REMOVE, rect(77, 0, 0, 0, 0));
        send_item(MODE_READ, rect(0, 0, 0, 0, 0));
        wait_drain();
    endtask

    task automatic test_full_list();
        while (list_q.size() < CAPACITY) send_item(MODE_INSERT, rand_rect(int'($urandom)));
        send_item(MODE_INSERT, rand_rect(8'hAA));
        send_item(MODE_READ, rect(0, 0, 0, 0, 0));
        while (list_q.size() > 0) send_item(MODE_REMOVE, rect(int'(list_q[$urandom_range(
            list_q.size() - 1)].id), 0, 0, 0, 0));
        send_item(MODE_READ, rect(0, 0, 0, 0, 0));
        wait_drain();
    endtask

    task automatic test_random(int items);
        int r;
        for (int k = 0; k < items; k++) begin
            r = int'($urandom_range(9));
            if (r < 5) send_item(MODE_INSERT, rand_rect(int'($urandom_range(15))));
            else if (r < 7)
                send_item(MODE_REMOVE, rect(int'($urandom_range(15)), 0, 0, 0, 0));
            else if (r < 9) send_item(MODE_READ, rand_rect(int'($urandom)));
            else send_item(2'($urandom_range(3)), rand_rect(int'($urandom)));
        end
        wait_drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_list();
        test_random(20);
        send_idle_pct = 74;
        test_random(20);
        send_idle_pct = 0; recv_stall_pct = 74;
        test_random(20);
        send_idle_pct = 34; recv_stall_pct = 34;
        test_random(20);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

[isometric_depth_order_insert_unit.f]
rtl/idoi_pkg.sv
rtl/idoi_datapath.sv
rtl/idoi_controller.sv
rtl/isometric_depth_order_insert_unit.sv
verif/tb.sv
